FILE: hdl/hcan_pkg.sv
// Package for the helix closest-approach block: widths, fixed-point constants, command
// and status types shared by the controller and the datapath, and the multiply schedule.
// No dependencies.
package hcan_pkg;

  localparam int POS_W         = 48;
  localparam int DIFF_W        = 49;
  localparam int ANG_W         = 32;
  localparam int THETA_W       = 30;
  localparam int ITER_W        = 10;
  localparam int PREC_W        = 28;
  localparam int STATUS_W      = 2;
  localparam int CFG_IDX_W     = 8;
  localparam int CFG_DATA_W    = 32;

  localparam int CORDIC_STAGES = 28;
  localparam int STG_W         = 5;
  localparam int CW            = 34;
  localparam int ATAN_W        = 30;

  localparam int ACC_W         = 63;
  localparam int MAG_W         = 60;
  localparam int OPB_W         = 32;
  localparam int PROD_W        = 64;
  localparam int WIDE_W        = 73;
  localparam int DIV_Q_W       = 33;
  localparam int DIV_CNT_W     = 6;

  localparam int NUM_MULS      = 9;
  localparam int MUL_IDX_W     = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_PREC = 8'd1;
  localparam logic [ITER_W-1:0]    MAX_ITER_RST  = 10'd20;
  localparam logic [PREC_W-1:0]    STEP_PREC_RST = 28'd1;

  localparam logic signed [CW-1:0] ANG_PI       = 34'sd843314857;
  localparam logic signed [CW-1:0] ANG_TWO_PI   = 34'sd1686629713;
  localparam logic signed [CW-1:0] ANG_HALF_PI  = 34'sd421657428;
  localparam logic signed [CW-1:0] CORDIC_GAIN  = 34'sd652032874;

  localparam logic [MAG_W-1:0]      SAT_MAG_U  = '1;
  localparam logic signed [ACC_W-1:0] SAT_MAG  = 63'sd1152921504606846975;
  localparam logic [DIV_Q_W-1:0]    COT_MAX_Q  = 33'd2147483647;
  localparam logic [DIV_Q_W-1:0]    STEP_MAX_Q = 33'd4294967296;
  localparam logic signed [ANG_W-1:0] COT_MAX  = 32'sh7FFFFFFF;
  localparam logic signed [CW-1:0]  PHI_HI     = 34'sd2147483647;
  localparam logic signed [CW-1:0]  PHI_LO     = -34'sd2147483648;

  typedef logic signed [POS_W-1:0]  pos_t;
  typedef logic signed [DIFF_W-1:0] diff_t;
  typedef logic signed [ANG_W-1:0]  ang_t;
  typedef logic signed [CW-1:0]     cw_t;
  typedef logic signed [ACC_W-1:0]  acc_t;

  typedef enum logic [1:0] {
    ST_CONVERGED = 2'd0,
    ST_NEG_D2    = 2'd1,
    ST_NOT_CONV  = 2'd2
  } res_status_e;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_COR_THETA,
    CMD_COR_PHI,
    CMD_COR_STEP,
    CMD_COT_START,
    CMD_DIV_STEP,
    CMD_COT_STORE,
    CMD_MUL_HI,
    CMD_MUL_LO,
    CMD_MUL_FIN,
    CMD_MUL_ACC,
    CMD_STEP_START,
    CMD_STEP_STORE,
    CMD_PHI_UPDATE,
    CMD_FINISH
  } dp_cmd_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_LOAD_T,
    S_COR_T,
    S_COT,
    S_COT_DIV,
    S_COT_STORE,
    S_LOAD_P,
    S_COR_P,
    S_LOOP,
    S_MUL_HI,
    S_MUL_LO,
    S_MUL_FIN,
    S_MUL_ACC,
    S_CHECK,
    S_STEP_DIV,
    S_STEP_STORE,
    S_UPDATE,
    S_CONV,
    S_FINISH
  } fsm_state_e;

  typedef enum logic [1:0] {A_RHO, A_T, A_DX, A_DY} a_sel_e;
  typedef enum logic [1:0] {B_PHI, B_COT, B_COS, B_SIN} b_sel_e;
  typedef enum logic [1:0] {SH_20, SH_28, SH_30} shift_e;
  typedef enum logic [2:0] {
    D_T_SET, D_T_DZ, D_A_SET, D_A_ADD, D_A_SAT, D_B_NEG, D_B_ADD, D_B_SAT
  } dst_e;

  typedef struct packed {
    a_sel_e a;
    b_sel_e b;
    shift_e sh;
    dst_e   dst;
  } mul_op_t;

  typedef struct packed {
    dp_cmd_e              cmd;
    logic [MUL_IDX_W-1:0] mul_idx;
    res_status_e          status;
  } dp_ctrl_t;

  typedef struct packed {
    logic cor_last;
    logic div_last;
    logic st_zero;
    logic skip_div;
    logic neg_d2;
    logic converged;
    logic n_at_max;
  } dp_stat_t;

  // Multiply schedule of one Newton step; A and B are built up term by term.
  function automatic mul_op_t mul_op(input logic [MUL_IDX_W-1:0] idx);
    mul_op_t op;
    case (idx)
      4'd0:    op = '{A_RHO, B_PHI, SH_28, D_T_SET};
      4'd1:    op = '{A_T,   B_COT, SH_20, D_T_DZ};
      4'd2:    op = '{A_DX,  B_COS, SH_30, D_A_SET};
      4'd3:    op = '{A_DY,  B_SIN, SH_30, D_A_ADD};
      4'd4:    op = '{A_T,   B_COT, SH_20, D_A_SAT};
      4'd5:    op = '{A_DX,  B_SIN, SH_30, D_B_NEG};
      4'd6:    op = '{A_DY,  B_COS, SH_30, D_B_ADD};
      4'd7:    op = '{A_RHO, B_COT, SH_20, D_T_SET};
      4'd8:    op = '{A_T,   B_COT, SH_20, D_B_SAT};
      default: op = '{A_RHO, B_PHI, SH_28, D_T_SET};
    endcase
    return op;
  endfunction

  function automatic acc_t sat_acc(input acc_t v);
    acc_t r;
    r = v;
    if (v > SAT_MAG) begin
      r = SAT_MAG;
    end else if (v < -SAT_MAG) begin
      r = -SAT_MAG;
    end
    return r;
  endfunction

  function automatic logic [ATAN_W-1:0] atan_q(input logic [STG_W-1:0] i);
    logic [ATAN_W-1:0] v;
    case (i)
      5'd0:    v = 30'd843314856;
      5'd1:    v = 30'd497837829;
      5'd2:    v = 30'd263043836;
      5'd3:    v = 30'd133525158;
      5'd4:    v = 30'd67021686;
      5'd5:    v = 30'd33543515;
      5'd6:    v = 30'd16775850;
      5'd7:    v = 30'd8388437;
      5'd8:    v = 30'd4194282;
      5'd9:    v = 30'd2097149;
      5'd10:   v = 30'd1048575;
      5'd11:   v = 30'd524287;
      5'd12:   v = 30'd262143;
      5'd13:   v = 30'd131071;
      5'd14:   v = 30'd65535;
      5'd15:   v = 30'd32767;
      5'd16:   v = 30'd16383;
      5'd17:   v = 30'd8191;
      5'd18:   v = 30'd4095;
      5'd19:   v = 30'd2047;
      5'd20:   v = 30'd1023;
      5'd21:   v = 30'd511;
      5'd22:   v = 30'd255;
      5'd23:   v = 30'd127;
      5'd24:   v = 30'd63;
      5'd25:   v = 30'd31;
      5'd26:   v = 30'd15;
      5'd27:   v = 30'd7;
      5'd28:   v = 30'd3;
      5'd29:   v = 30'd1;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

FILE: hdl/hcan_in_if.sv
// Input channel of the helix closest-approach block: one track and vertex item.
// Depends on hcan_pkg.
interface hcan_in_if import hcan_pkg::*; ();
  logic              valid;
  logic              ready;
  pos_t              center_x;
  pos_t              center_y;
  pos_t              center_z;
  pos_t              vertex_x;
  pos_t              vertex_y;
  pos_t              vertex_z;
  ang_t              start_phi;
  logic [THETA_W-1:0] polar_angle;
  pos_t              helix_radius;

  modport source (output valid, center_x, center_y, center_z, vertex_x, vertex_y, vertex_z,
                  start_phi, polar_angle, helix_radius, input ready);
  modport sink (input valid, center_x, center_y, center_z, vertex_x, vertex_y, vertex_z,
                start_phi, polar_angle, helix_radius, output ready);
endinterface

FILE: hdl/hcan_out_if.sv
// Result channel of the helix closest-approach block: final azimuth, status, step count.
// Depends on hcan_pkg.
interface hcan_out_if import hcan_pkg::*; ();
  logic                valid;
  logic                ready;
  ang_t                final_phi;
  logic [STATUS_W-1:0] status;
  logic [ITER_W-1:0]   iterations_used;

  modport source (output valid, final_phi, status, iterations_used, input ready);
  modport sink (input valid, final_phi, status, iterations_used, output ready);
endinterface

FILE: hdl/hcan_cfg_if.sv
// Register write channel of the helix closest-approach block.
// Depends on hcan_pkg.
interface hcan_cfg_if import hcan_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  reg_index;
  logic [CFG_DATA_W-1:0] wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink (input valid, reg_index, wdata, output ready);
endinterface

FILE: hdl/hcan_ctrl.sv
// Sequencer of the helix closest-approach block: walks CORDIC, division, multiply and
// update phases and owns the item handshakes. Depends on hcan_pkg.
module hcan_ctrl import hcan_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  dp_stat_t stat_i,
  output dp_ctrl_t ctrl_o
);

  fsm_state_e           state_q, state_d;
  logic [MUL_IDX_W-1:0] idx_q, idx_d;
  res_status_e          fst_q, fst_d;
  logic                 out_valid_q, out_valid_d;
  logic                 fin;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      fst_q       <= ST_NOT_CONV;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      fst_q       <= fst_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d        = state_q;
    idx_d          = idx_q;
    fst_d          = fst_q;
    in_ready_o     = 1'b0;
    fin            = 1'b0;
    ctrl_o.cmd     = CMD_NONE;
    ctrl_o.mul_idx = idx_q;
    ctrl_o.status  = fst_q;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctrl_o.cmd = CMD_LOAD;
          state_d    = S_LOAD_T;
        end
      end
      S_LOAD_T: begin
        ctrl_o.cmd = CMD_COR_THETA;
        state_d    = S_COR_T;
      end
      S_COR_T: begin
        ctrl_o.cmd = CMD_COR_STEP;
        if (stat_i.cor_last) begin
          state_d = S_COT;
        end
      end
      S_COT: begin
        // A zero sine sets the cotangent directly and skips the division.
        ctrl_o.cmd = CMD_COT_START;
        state_d    = stat_i.st_zero ? S_LOAD_P : S_COT_DIV;
      end
      S_COT_DIV: begin
        ctrl_o.cmd = CMD_DIV_STEP;
        if (stat_i.div_last) begin
          state_d = S_COT_STORE;
        end
      end
      S_COT_STORE: begin
        ctrl_o.cmd = CMD_COT_STORE;
        state_d    = S_LOAD_P;
      end
      S_LOAD_P: begin
        ctrl_o.cmd = CMD_COR_PHI;
        state_d    = S_COR_P;
      end
      S_COR_P: begin
        ctrl_o.cmd = CMD_COR_STEP;
        if (stat_i.cor_last) begin
          state_d = S_LOOP;
        end
      end
      S_LOOP: begin
        if (stat_i.n_at_max) begin
          fst_d   = ST_NOT_CONV;
          state_d = S_FINISH;
        end else begin
          idx_d   = '0;
          state_d = S_MUL_HI;
        end
      end
      S_MUL_HI: begin
        ctrl_o.cmd = CMD_MUL_HI;
        state_d    = S_MUL_LO;
      end
      S_MUL_LO: begin
        ctrl_o.cmd = CMD_MUL_LO;
        state_d    = S_MUL_FIN;
      end
      S_MUL_FIN: begin
        ctrl_o.cmd = CMD_MUL_FIN;
        state_d    = S_MUL_ACC;
      end
      S_MUL_ACC: begin
        ctrl_o.cmd = CMD_MUL_ACC;
        if (idx_q == MUL_IDX_W'(NUM_MULS - 1)) begin
          state_d = S_CHECK;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = S_MUL_HI;
        end
      end
      S_CHECK: begin
        if (stat_i.neg_d2) begin
          fst_d   = ST_NEG_D2;
          state_d = S_FINISH;
        end else begin
          ctrl_o.cmd = CMD_STEP_START;
          state_d    = stat_i.skip_div ? S_UPDATE : S_STEP_DIV;
        end
      end
      S_STEP_DIV: begin
        ctrl_o.cmd = CMD_DIV_STEP;
        if (stat_i.div_last) begin
          state_d = S_STEP_STORE;
        end
      end
      S_STEP_STORE: begin
        ctrl_o.cmd = CMD_STEP_STORE;
        state_d    = S_UPDATE;
      end
      S_UPDATE: begin
        ctrl_o.cmd = CMD_PHI_UPDATE;
        state_d    = S_CONV;
      end
      S_CONV: begin
        if (stat_i.converged) begin
          fst_d   = ST_CONVERGED;
          state_d = S_FINISH;
        end else begin
          state_d = S_LOAD_P;
        end
      end
      S_FINISH: begin
        // Wait until the previous result has left the output register.
        if (!out_valid_q || out_ready_i) begin
          ctrl_o.cmd = CMD_FINISH;
          fin        = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (fin) begin
      out_valid_d = 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

FILE: hdl/hcan_datapath.sv
// Datapath of the helix closest-approach block: registers, iterative CORDIC, shared
// 32x32 multiplier, one-bit-per-cycle divider and result register. Depends on hcan_pkg.
module hcan_datapath import hcan_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  dp_ctrl_t              ctrl_i,
  output dp_stat_t              stat_o,
  input  logic                  cfg_valid_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  pos_t                  center_x_i,
  input  pos_t                  center_y_i,
  input  pos_t                  center_z_i,
  input  pos_t                  vertex_x_i,
  input  pos_t                  vertex_y_i,
  input  pos_t                  vertex_z_i,
  input  ang_t                  start_phi_i,
  input  logic [THETA_W-1:0]    polar_angle_i,
  input  pos_t                  helix_radius_i,
  output ang_t                  final_phi_o,
  output logic [STATUS_W-1:0]   status_o,
  output logic [ITER_W-1:0]     iterations_used_o
);

  logic [ITER_W-1:0] max_iter_q;
  logic [PREC_W-1:0] prec_q;

  diff_t              dx_q, dy_q, dz_q;
  pos_t               rho_q;
  logic [THETA_W-1:0] theta_q;
  ang_t               phi_q, cot_q;
  cw_t                cx_q, cy_q, cz_q;
  logic               flip_q;
  logic [STG_W-1:0]   stg_q;
  acc_t               t_q, acca_q, accb_q, r_q;
  logic [MAG_W-1:0]   hi_q;
  logic [PROD_W-1:0]  lo_q;
  logic [MAG_W:0]     rem_q;
  logic [MAG_W-1:0]   den_q;
  logic [DIV_Q_W-1:0] low_q, quo_q;
  logic               ovf_q, cot_neg_q, dneg_q;
  logic [DIV_CNT_W-1:0] dcnt_q;
  logic [DIV_Q_W-1:0] dmag_q;
  logic [ITER_W-1:0]  n_q;
  ang_t               out_phi_q;
  logic [STATUS_W-1:0] out_status_q;
  logic [ITER_W-1:0]  out_iter_q;

  // Register writes; an index beyond the list is ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_iter_q <= MAX_ITER_RST;
      prec_q     <= STEP_PREC_RST;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_MAX_ITER) begin
        max_iter_q <= cfg_data_i[ITER_W-1:0];
      end else if (cfg_index_i == CFG_STEP_PREC) begin
        prec_q <= cfg_data_i[PREC_W-1:0];
      end
    end
  end

  // Multiplier operand selection and magnitudes.
  mul_op_t           op;
  acc_t              a_val, a_abs;
  cw_t               b_val, b_abs;
  logic              a_neg, b_neg;
  logic [MAG_W-1:0]  ua;
  logic [OPB_W-1:0]  ub, mul_x;
  logic [PROD_W-1:0] prod;

  always_comb begin
    op = mul_op(ctrl_i.mul_idx);
    case (op.a)
      A_RHO:   a_val = {{(ACC_W-POS_W){rho_q[POS_W-1]}}, rho_q};
      A_T:     a_val = t_q;
      A_DX:    a_val = {{(ACC_W-DIFF_W){dx_q[DIFF_W-1]}}, dx_q};
      A_DY:    a_val = {{(ACC_W-DIFF_W){dy_q[DIFF_W-1]}}, dy_q};
      default: a_val = t_q;
    endcase
    case (op.b)
      B_PHI:   b_val = {{(CW-ANG_W){phi_q[ANG_W-1]}}, phi_q};
      B_COT:   b_val = {{(CW-ANG_W){cot_q[ANG_W-1]}}, cot_q};
      B_COS:   b_val = cx_q;
      B_SIN:   b_val = cy_q;
      default: b_val = cx_q;
    endcase
    a_neg = a_val[ACC_W-1];
    b_neg = b_val[CW-1];
    a_abs = a_neg ? -a_val : a_val;
    b_abs = b_neg ? -b_val : b_val;
    ua    = a_abs[MAG_W-1:0];
    ub    = b_abs[OPB_W-1:0];
    mul_x = (ctrl_i.cmd == CMD_MUL_HI) ? {{(2*OPB_W-MAG_W){1'b0}}, ua[MAG_W-1:OPB_W]}
                                       : ua[OPB_W-1:0];
    prod  = PROD_W'(mul_x) * PROD_W'(ub);
  end

  // Recombination of the partial products with truncation and saturation.
  logic              over;
  logic [WIDE_W-1:0] wide;
  logic [MAG_W-1:0]  rmag;
  acc_t              r_val;

  always_comb begin
    case (op.sh)
      SH_20: begin
        over = hi_q > (SAT_MAG_U >> 12);
        wide = (WIDE_W'(hi_q) << 12) + WIDE_W'(lo_q >> 20);
      end
      SH_28: begin
        over = hi_q > (SAT_MAG_U >> 4);
        wide = (WIDE_W'(hi_q) << 4) + WIDE_W'(lo_q >> 28);
      end
      SH_30: begin
        over = hi_q > (SAT_MAG_U >> 2);
        wide = (WIDE_W'(hi_q) << 2) + WIDE_W'(lo_q >> 30);
      end
      default: begin
        over = 1'b1;
        wide = '0;
      end
    endcase
    rmag  = (over || wide > WIDE_W'(SAT_MAG_U)) ? SAT_MAG_U : wide[MAG_W-1:0];
    r_val = {{(ACC_W-MAG_W){1'b0}}, rmag};
    if (a_neg ^ b_neg) begin
      r_val = -r_val;
    end
  end

  acc_t dz_ext;
  assign dz_ext = {{(ACC_W-DIFF_W){dz_q[DIFF_W-1]}}, dz_q};

  // Divider set-up: the cotangent uses 20 fraction bits, the Newton step 28.
  logic             k28;
  logic [MAG_W-1:0] dn, dd;
  cw_t              cx_abs, cy_abs;
  acc_t             accA_abs, accB_abs;
  logic [MAG_W:0]   rem_init;
  logic [DIV_Q_W-1:0] low_init;

  always_comb begin
    cx_abs   = cx_q[CW-1] ? -cx_q : cx_q;
    cy_abs   = cy_q[CW-1] ? -cy_q : cy_q;
    accA_abs = acca_q[ACC_W-1] ? -acca_q : acca_q;
    accB_abs = accb_q[ACC_W-1] ? -accb_q : accb_q;
    k28      = (ctrl_i.cmd != CMD_COT_START);
    if (k28) begin
      dn       = accA_abs[MAG_W-1:0];
      dd       = accB_abs[MAG_W-1:0];
      rem_init = {6'b0, dn[MAG_W-1:5]};
      low_init = {dn[4:0], 28'b0};
    end else begin
      dn       = {{(MAG_W-CW){1'b0}}, cx_abs};
      dd       = {{(MAG_W-CW){1'b0}}, cy_abs};
      rem_init = {14'b0, dn[MAG_W-1:13]};
      low_init = {dn[12:0], 20'b0};
    end
  end

  logic [MAG_W:0] rs;
  logic           ge;
  assign rs = {rem_q[MAG_W-1:0], low_q[DIV_Q_W-1]};
  assign ge = rs >= {1'b0, den_q};

  logic [DIV_Q_W-1:0] cot_mag, step_mag;
  assign cot_mag  = (ovf_q || quo_q > COT_MAX_Q) ? COT_MAX_Q : quo_q;
  assign step_mag = (ovf_q || quo_q > STEP_MAX_Q) ? STEP_MAX_Q : quo_q;

  // CORDIC angle reduction into [-pi/2, pi/2] with a final sign flip.
  cw_t  ang, a1, a2;
  logic flip;

  always_comb begin
    if (ctrl_i.cmd == CMD_COR_THETA) begin
      ang = {{(CW-THETA_W){1'b0}}, theta_q};
    end else begin
      ang = {{(CW-ANG_W){phi_q[ANG_W-1]}}, phi_q};
    end
    a1 = ang;
    if (ang > ANG_PI) begin
      a1 = ang - ANG_TWO_PI;
    end else if (ang < -ANG_PI) begin
      a1 = ang + ANG_TWO_PI;
    end
    a2   = a1;
    flip = 1'b0;
    if (a1 > ANG_HALF_PI) begin
      a2   = a1 - ANG_PI;
      flip = 1'b1;
    end else if (a1 < -ANG_HALF_PI) begin
      a2   = a1 + ANG_PI;
      flip = 1'b1;
    end
  end

  cw_t xs, ys, at, nx, ny, nz;
  always_comb begin
    xs = cx_q >>> stg_q;
    ys = cy_q >>> stg_q;
    at = {{(CW-ATAN_W){1'b0}}, atan_q(stg_q)};
    if (!cz_q[CW-1]) begin
      nx = cx_q - ys;
      ny = cy_q + xs;
      nz = cz_q - at;
    end else begin
      nx = cx_q + ys;
      ny = cy_q - xs;
      nz = cz_q + at;
    end
    if (stat_o.cor_last && flip_q) begin
      nx = -nx;
      ny = -ny;
    end
  end

  cw_t delta, phi_sum;
  always_comb begin
    delta   = {1'b0, dmag_q};
    if (dneg_q) begin
      delta = -delta;
    end
    phi_sum = {{(CW-ANG_W){phi_q[ANG_W-1]}}, phi_q} + delta;
    if (phi_sum > PHI_HI) begin
      phi_sum = PHI_HI;
    end else if (phi_sum < PHI_LO) begin
      phi_sum = PHI_LO;
    end
  end

  always_ff @(posedge clk_i) begin
    case (ctrl_i.cmd)
      CMD_LOAD: begin
        dx_q    <= {vertex_x_i[POS_W-1], vertex_x_i} - {center_x_i[POS_W-1], center_x_i};
        dy_q    <= {vertex_y_i[POS_W-1], vertex_y_i} - {center_y_i[POS_W-1], center_y_i};
        dz_q    <= {vertex_z_i[POS_W-1], vertex_z_i} - {center_z_i[POS_W-1], center_z_i};
        rho_q   <= helix_radius_i;
        theta_q <= polar_angle_i;
        phi_q   <= start_phi_i;
        n_q     <= '0;
      end
      CMD_COR_THETA, CMD_COR_PHI: begin
        cx_q   <= CORDIC_GAIN;
        cy_q   <= '0;
        cz_q   <= a2 <<< 2;
        flip_q <= flip;
        stg_q  <= '0;
      end
      CMD_COR_STEP: begin
        cx_q  <= nx;
        cy_q  <= ny;
        cz_q  <= nz;
        stg_q <= stg_q + 1'b1;
      end
      CMD_COT_START: begin
        cot_neg_q <= cx_q[CW-1] ^ cy_q[CW-1];
        cot_q     <= cx_q[CW-1] ? -COT_MAX : COT_MAX;
        rem_q     <= rem_init;
        den_q     <= dd;
        low_q     <= low_init;
        quo_q     <= '0;
        ovf_q     <= rem_init >= {1'b0, dd};
        dcnt_q    <= '0;
      end
      CMD_DIV_STEP: begin
        rem_q  <= ge ? rs - {1'b0, den_q} : rs;
        quo_q  <= {quo_q[DIV_Q_W-2:0], ge};
        low_q  <= low_q << 1;
        dcnt_q <= dcnt_q + 1'b1;
      end
      CMD_COT_STORE: begin
        cot_q <= cot_neg_q ? -ang_t'(cot_mag[ANG_W-1:0]) : ang_t'(cot_mag[ANG_W-1:0]);
      end
      CMD_MUL_HI: begin
        hi_q <= prod[MAG_W-1:0];
      end
      CMD_MUL_LO: begin
        lo_q <= prod;
      end
      CMD_MUL_FIN: begin
        r_q <= r_val;
      end
      CMD_MUL_ACC: begin
        case (op.dst)
          D_T_SET: t_q    <= r_q;
          D_T_DZ:  t_q    <= sat_acc(dz_ext + r_q);
          D_A_SET: acca_q <= r_q;
          D_A_ADD: acca_q <= acca_q + r_q;
          D_A_SAT: acca_q <= sat_acc(acca_q + r_q);
          D_B_NEG: accb_q <= -r_q;
          D_B_ADD: accb_q <= accb_q + r_q;
          D_B_SAT: accb_q <= sat_acc(accb_q + r_q);
          default: t_q    <= r_q;
        endcase
      end
      CMD_STEP_START: begin
        if (stat_o.skip_div) begin
          // Zero curvature term: full-size step against the sign of A.
          dmag_q <= STEP_MAX_Q;
          dneg_q <= !acca_q[ACC_W-1] && (acca_q != '0);
        end else begin
          dneg_q <= acca_q[ACC_W-1] == accb_q[ACC_W-1];
        end
        rem_q  <= rem_init;
        den_q  <= dd;
        low_q  <= low_init;
        quo_q  <= '0;
        ovf_q  <= rem_init >= {1'b0, dd};
        dcnt_q <= '0;
      end
      CMD_STEP_STORE: begin
        dmag_q <= step_mag;
      end
      CMD_PHI_UPDATE: begin
        phi_q <= phi_sum[ANG_W-1:0];
        n_q   <= n_q + 1'b1;
      end
      CMD_FINISH: begin
        out_phi_q    <= phi_q;
        out_status_q <= ctrl_i.status;
        out_iter_q   <= n_q;
      end
      default: begin
      end
    endcase
  end

  logic rho_zero, b_zero;
  assign rho_zero = (rho_q == '0);
  assign b_zero   = (accb_q == '0);

  always_comb begin
    stat_o.cor_last  = (stg_q == STG_W'(CORDIC_STAGES - 1));
    stat_o.div_last  = (dcnt_q == DIV_CNT_W'(DIV_Q_W - 1));
    stat_o.st_zero   = (cy_q == '0);
    stat_o.skip_div  = rho_zero || b_zero;
    stat_o.neg_d2    = (rho_q[POS_W-1] && !accb_q[ACC_W-1] && !b_zero) ||
                       (!rho_q[POS_W-1] && !rho_zero && accb_q[ACC_W-1]);
    stat_o.converged = dmag_q < DIV_Q_W'(prec_q);
    stat_o.n_at_max  = (n_q == max_iter_q);
  end

  assign final_phi_o       = out_phi_q;
  assign status_o          = out_status_q;
  assign iterations_used_o = out_iter_q;

endmodule

FILE: hdl/helix_closest_approach_newton.sv
// Top level of the helix closest-approach block: Newton search on the azimuth.
// Depends on hcan_pkg, the three channel interfaces, hcan_ctrl and hcan_datapath.
//
//   Channel   Modport  Carries
//   in_i      sink     centre, vertex, start azimuth, polar angle, radius
//   out_o     source   final azimuth, status, steps used
//   cfg_i     sink     register index and write data (always ready)
//
// An item runs a set-up of two CORDIC passes and a cotangent division, then per Newton
// step nine products on the one 32x32 multiplier (high part, low part, recombine,
// accumulate), a one-bit-per-cycle division and a CORDIC.
// Reset is asynchronous; it returns the sequencer to idle and the registers to 20 and 1.
// A new item is taken only when idle; a result waits in the output register while the
// next item runs, and a finished item holds until that register has been read.
module helix_closest_approach_newton import hcan_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  hcan_in_if.sink    in_i,
  hcan_out_if.source out_o,
  hcan_cfg_if.sink   cfg_i
);

  dp_ctrl_t ctrl;
  dp_stat_t stat;

  assign cfg_i.ready = 1'b1;

  hcan_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .stat_i      (stat),
    .ctrl_o      (ctrl)
  );

  hcan_datapath u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .ctrl_i            (ctrl),
    .stat_o            (stat),
    .cfg_valid_i       (cfg_i.valid),
    .cfg_index_i       (cfg_i.reg_index),
    .cfg_data_i        (cfg_i.wdata),
    .center_x_i        (in_i.center_x),
    .center_y_i        (in_i.center_y),
    .center_z_i        (in_i.center_z),
    .vertex_x_i        (in_i.vertex_x),
    .vertex_y_i        (in_i.vertex_y),
    .vertex_z_i        (in_i.vertex_z),
    .start_phi_i       (in_i.start_phi),
    .polar_angle_i     (in_i.polar_angle),
    .helix_radius_i    (in_i.helix_radius),
    .final_phi_o       (out_o.final_phi),
    .status_o          (out_o.status),
    .iterations_used_o (out_o.iterations_used)
  );

endmodule

FILE: verif/helix_closest_approach_newton_tb.sv
// Testbench for helix_closest_approach_newton: a table of directed track items, then
// random phases under several register settings, checked by predictor or fixed values.
// Depends on hcan_pkg, the three channel interfaces and the block itself.
module helix_closest_approach_newton_tb;
  import hcan_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int  CYCLE_LIMIT = 6000000;
  localparam longint SATU = 64'd1152921504606846975;
  localparam longint COTM = 64'd2147483647;
  localparam longint unsigned STEPM = 64'd4294967296;
  localparam longint PMAX = 64'sh7FFF_FFFF_FFFF;
  localparam longint PMIN = -64'sh8000_0000_0000;

  typedef struct {
    pos_t cx, cy, cz, vx, vy, vz;
    ang_t phi;
    logic [THETA_W-1:0] th;
    pos_t rho;
    int   iters;
    bit   known;
    ang_t e_phi;
    logic [STATUS_W-1:0] e_st;
    logic [ITER_W-1:0]   e_n;
  } track_t;

  typedef struct {
    ang_t                phi;
    logic [STATUS_W-1:0] st;
    logic [ITER_W-1:0]   n;
  } approach_t;

  typedef struct {
    logic [CFG_DATA_W-1:0] iter_word;
    logic [CFG_DATA_W-1:0] prec_word;
    int                    count;
  } phase_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   cycles = 0;
  int   err_cnt = 0;
  bit   calm = 1'b0;

  logic [ITER_W-1:0] max_iter_m = MAX_ITER_RST;
  logic [PREC_W-1:0] prec_m = STEP_PREC_RST;

  approach_t pending_results[$];
  track_t    dir_tab[$];

  const longint atan_tab[32] = '{
    843314856, 497837829, 263043836, 133525158, 67021686, 33543515, 16775850, 8388437,
    4194282, 2097149, 1048575, 524287, 262143, 131071, 65535, 32767, 16383, 8191, 4095,
    2047, 1023, 511, 255, 127, 63, 31, 15, 7, 3, 1, 0, 0};

  hcan_in_if  trk_if ();
  hcan_out_if res_if ();
  hcan_cfg_if cfg_if ();

  helix_closest_approach_newton DUT (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (trk_if),
    .out_o (res_if),
    .cfg_i (cfg_if)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("** helix_closest_approach_newton: FAILED **");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor
  function automatic longint sat60(longint v);
    if (v > SATU) return SATU;
    if (v < -SATU) return -SATU;
    return v;
  endfunction

  function automatic longint unsigned umag(longint v);
    return v < 0 ? -v : v;
  endfunction

  // Fixed-point product, magnitude truncated toward zero and saturated.
  function automatic longint fx_mul(longint a, longint b, int s);
    bit neg;
    longint unsigned ua, ub, hi, lo, r;
    int sh;
    neg = (a < 0) != (b < 0);
    ua = umag(a);
    ub = umag(b);
    sh = 32 - s;
    if (ub > 64'hFFFF_FFFF) ub = 64'hFFFF_FFFF;
    hi = (ua >> 32) * ub;
    lo = (ua & 64'hFFFF_FFFF) * ub;
    if (hi > (SATU >> sh)) begin
      r = SATU;
    end else begin
      r = (hi << sh) + (lo >> s);
      if (r > SATU) r = SATU;
    end
    return neg ? -longint'(r) : longint'(r);
  endfunction

  task automatic sin_cos(input longint a, output longint c, output longint s);
    longint x, y, z, nx;
    bit flip;
    x = CORDIC_GAIN;
    y = 0;
    flip = 1'b0;
    while (a > ANG_PI) a -= ANG_TWO_PI;
    while (a < -ANG_PI) a += ANG_TWO_PI;
    if (a > ANG_HALF_PI) begin
      a -= ANG_PI;
      flip = 1'b1;
    end else if (a < -ANG_HALF_PI) begin
      a += ANG_PI;
      flip = 1'b1;
    end
    z = a * 4;
    for (int i = 0; i < CORDIC_STAGES; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z -= atan_tab[i];
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z += atan_tab[i];
      end
      x = nx;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  function automatic longint unsigned step_quot(longint unsigned ua, longint unsigned ub);
    longint unsigned q, rem;
    q = ua / ub;
    rem = ua % ub;
    if (q >= 32) return STEPM;
    for (int i = 0; i < 28; i++) begin
      rem = rem << 1;
      q = q << 1;
      if (rem >= ub) begin
        rem -= ub;
        q |= 1;
      end
    end
    return q > STEPM ? STEPM : q;
  endfunction

  task automatic closest_phi_predict(input track_t t, output approach_t r);
    longint dx, dy, dz, phi, rho, ct, st, cp, sp, cot, a, b, inner;
    longint unsigned q, dmag;
    int n;
    bit dneg;
    logic [STATUS_W-1:0] status;
    dx = longint'(t.vx) - longint'(t.cx);
    dy = longint'(t.vy) - longint'(t.cy);
    dz = longint'(t.vz) - longint'(t.cz);
    phi = longint'(t.phi);
    rho = longint'(t.rho);
    n = 0;
    status = ST_NOT_CONV;
    sin_cos(longint'(t.th), ct, st);
    if (st == 0) begin
      cot = ct < 0 ? -COTM : COTM;
    end else begin
      q = (umag(ct) << 20) / umag(st);
      if (q > COTM) q = COTM;
      cot = ((ct < 0) != (st < 0)) ? -longint'(q) : longint'(q);
    end
    sin_cos(phi, cp, sp);
    while (n < max_iter_m) begin
      inner = sat60(dz + fx_mul(fx_mul(rho, phi, 28), cot, 20));
      a = sat60(fx_mul(dx, cp, 30) + fx_mul(dy, sp, 30) + fx_mul(inner, cot, 20));
      b = sat60(-fx_mul(dx, sp, 30) + fx_mul(dy, cp, 30) +
                fx_mul(fx_mul(rho, cot, 20), cot, 20));
      if ((rho < 0 && b > 0) || (rho > 0 && b < 0)) begin
        status = ST_NEG_D2;
        break;
      end
      if (rho == 0 || b == 0) begin
        dmag = STEPM;
        dneg = a > 0;
      end else begin
        dmag = step_quot(umag(a), umag(b));
        dneg = (a < 0) == (b < 0);
      end
      phi += dneg ? -longint'(dmag) : longint'(dmag);
      if (phi > 64'sd2147483647) phi = 64'sd2147483647;
      if (phi < -64'sd2147483648) phi = -64'sd2147483648;
      sin_cos(phi, cp, sp);
      n++;
      if (dmag < prec_m) begin
        status = ST_CONVERGED;
        break;
      end
    end
    r.phi = ang_t'(phi);
    r.st = status;
    r.n = n[ITER_W-1:0];
  endtask

  // ---------------------------------------------------------------- result check
  always @(negedge clk) begin
    if (!rst_n) res_if.ready <= 1'b0;
    else res_if.ready <= calm ? 1'b1 : ($urandom_range(99) >= 18);
  end

  always @(posedge clk) begin
    approach_t e;
    if (rst_n && res_if.valid && res_if.ready) begin
      if (pending_results.size() == 0) begin
        $error("result with no item outstanding: phi %0d", res_if.final_phi);
        err_cnt++;
      end else begin
        e = pending_results.pop_front();
        if (res_if.final_phi !== e.phi) begin
          $error("final_phi: expected %0d, got %0d", e.phi, res_if.final_phi);
          err_cnt++;
        end
        if (res_if.status !== e.st) begin
          $error("status: expected %0d, got %0d", e.st, res_if.status);
          err_cnt++;
        end
        if (res_if.iterations_used !== e.n) begin
          $error("iterations_used: expected %0d, got %0d", e.n, res_if.iterations_used);
          err_cnt++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- stimulus
  function automatic track_t mk(longint cx, longint cy, longint cz, longint vx, longint vy,
                                longint vz, longint phi, longint th, longint rho, int iters);
    track_t t;
    t.cx = cx; t.cy = cy; t.cz = cz;
    t.vx = vx; t.vy = vy; t.vz = vz;
    t.phi = phi;
    t.th = th;
    t.rho = rho;
    t.iters = iters;
    t.known = 1'b0;
    t.e_phi = '0;
    t.e_st = '0;
    t.e_n = '0;
    return t;
  endfunction

  task automatic send_track(input track_t t);
    approach_t r;
    if (!calm && $urandom_range(99) < 18) begin
      trk_if.valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < 18);
    end
    trk_if.valid <= 1'b1;
    trk_if.center_x <= t.cx;
    trk_if.center_y <= t.cy;
    trk_if.center_z <= t.cz;
    trk_if.vertex_x <= t.vx;
    trk_if.vertex_y <= t.vy;
    trk_if.vertex_z <= t.vz;
    trk_if.start_phi <= t.phi;
    trk_if.polar_angle <= t.th;
    trk_if.helix_radius <= t.rho;
    do @(posedge clk); while (!trk_if.ready);
    if (t.known) begin
      r.phi = t.e_phi;
      r.st = t.e_st;
      r.n = t.e_n;
    end else begin
      closest_phi_predict(t, r);
    end
    pending_results.push_back(r);
    @(negedge clk);
  endtask

  // Drains the block so that a register write lands while it is idle.
  task automatic drain;
    trk_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    cfg_if.valid <= 1'b1;
    cfg_if.reg_index <= idx;
    cfg_if.wdata <= d;
    do @(posedge clk); while (!cfg_if.ready);
    if (idx == CFG_MAX_ITER) max_iter_m = d[ITER_W-1:0];
    else if (idx == CFG_STEP_PREC) prec_m = d[PREC_W-1:0];
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  function automatic track_t random_track();
    track_t t;
    longint rm, cx, cy, cz;
    int unsigned r32;
    if ($urandom_range(99) < 25) begin
      t = mk({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
             {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
             $urandom, $urandom, {$urandom, $urandom}, 0);
    end else begin
      // Plausible track: vertex within a couple of radii of the helix centre.
      r32 = $urandom_range(327680000, 655360);
      rm = r32;
      cx = longint'($signed($urandom)) <<< 4;
      cy = longint'($signed($urandom)) <<< 4;
      cz = longint'($signed($urandom)) <<< 2;
      t = mk(cx, cy, cz,
             cx + longint'($urandom_range(0, 3 * r32)) - (3 * rm) / 2,
             cy + longint'($urandom_range(0, 3 * r32)) - (3 * rm) / 2,
             cz + longint'($urandom_range(0, 2 * r32)) - rm,
             $urandom, $urandom_range(783314857, 60000000),
             $urandom_range(1) ? rm : -rm, 0);
      if ($urandom_range(9) == 0) t.th = $urandom_range(2000);
    end
    return t;
  endfunction

  initial begin
    phase_t phases[$];
    track_t t;
    logic [ITER_W-1:0] cur_iter;
    trk_if.valid = 1'b0;
    trk_if.center_x = '0; trk_if.center_y = '0; trk_if.center_z = '0;
    trk_if.vertex_x = '0; trk_if.vertex_y = '0; trk_if.vertex_z = '0;
    trk_if.start_phi = '0; trk_if.polar_angle = '0; trk_if.helix_radius = '0;
    cfg_if.valid = 1'b0;
    cfg_if.reg_index = '0;
    cfg_if.wdata = '0;

    // Directed rows; those up to here run under the reset settings.
    dir_tab.push_back(mk(0, 0, 0, 65536000, 3276800, 655360, 0, ANG_HALF_PI, 65536000, 20));
    dir_tab.push_back(mk(0, 0, 0, -65536000, 0, 0, 300000000, 300000000, -65536000, 20));
    dir_tab.push_back(mk(0, 0, 0, 655360, 655360, 655360, 0, ANG_HALF_PI, 0, 20));
    dir_tab.push_back(mk(65536, 65536, 65536, 65536, 65536, 65536, 0, ANG_HALF_PI,
                         6553600, 20));
    dir_tab.push_back(mk(0, 0, 0, 6553600, 0, 6553600, 0, 0, 6553600, 20));
    dir_tab.push_back(mk(0, 0, 0, 6553600, 0, 6553600, 0, 843314856, 6553600, 20));
    dir_tab.push_back(mk(0, 0, 0, 6553600, 6553600, 0, 1000, 30'h3FFF_FFFF, -6553600, 20));
    dir_tab.push_back(mk(0, 0, 0, -655360000, 0, 0, 0, ANG_HALF_PI, 65536000, 20));
    dir_tab.push_back(mk(PMAX, PMAX, PMAX, PMAX, PMAX, PMAX, 32'sh7FFF_FFFF, 843314856,
                         PMAX, 20));
    dir_tab.push_back(mk(PMIN, PMIN, PMIN, PMIN, PMIN, PMIN, -64'sd2147483648, 0,
                         PMIN, 20));
    dir_tab.push_back(mk(PMIN, PMAX, PMIN, PMAX, PMIN, PMAX, 32'sh7FFF_FFFF, 1,
                         PMIN, 20));
    dir_tab.push_back(mk(PMAX, PMIN, PMAX, PMIN, PMAX, PMIN, -64'sd2147483648,
                         ANG_HALF_PI, PMAX, 20));
    dir_tab.push_back(mk(0, 0, 0, 3276800, 3276800, 0, -843314857, 200000000, 3276800, 20));
    // With no steps allowed the start azimuth comes straight back.
    t = mk(0, 0, 0, 6553600, 0, 0, 32'sh1234_5678, ANG_HALF_PI, 6553600, 0);
    t.known = 1'b1; t.e_phi = 32'sh1234_5678; t.e_st = ST_NOT_CONV; t.e_n = '0;
    dir_tab.push_back(t);
    t = mk(PMAX, PMAX, PMAX, PMIN, PMIN, PMIN, 32'sh7FFF_FFFF, 843314856, PMIN, 0);
    t.known = 1'b1; t.e_phi = 32'sh7FFF_FFFF; t.e_st = ST_NOT_CONV; t.e_n = '0;
    dir_tab.push_back(t);
    t = mk(PMIN, PMIN, PMIN, PMAX, PMAX, PMAX, -64'sd2147483648, 0, 0, 0);
    t.known = 1'b1; t.e_phi = 32'sh8000_0000; t.e_st = ST_NOT_CONV; t.e_n = '0;
    dir_tab.push_back(t);

    // Raw register words; upper bits beyond each register's width are dropped.
    phases.push_back('{32'd8, 32'd4096, 60});
    phases.push_back('{32'hFFFF_FC14, 32'hF000_0001, 60});
    phases.push_back('{32'd50, 32'd268435455, 60});
    phases.push_back('{32'd5, 32'd0, 60});
    phases.push_back('{32'd1023, 32'd0, 2});
    phases.push_back('{32'd30, 32'd16, 58});

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    cur_iter = MAX_ITER_RST;
    foreach (dir_tab[i]) begin
      if (dir_tab[i].iters != cur_iter) begin
        drain();
        // A write beyond the two registers must leave both untouched.
        write_reg(8'd2, 32'hFFFF_FFFF);
        write_reg(CFG_MAX_ITER, 32'h0000_0400);
        cur_iter = dir_tab[i].iters;
      end
      send_track(dir_tab[i]);
    end

    foreach (phases[p]) begin
      drain();
      write_reg(CFG_MAX_ITER, phases[p].iter_word);
      write_reg(CFG_STEP_PREC, phases[p].prec_word);
      for (int k = 0; k < phases[p].count; k++) begin
        calm = (p == 2 && k >= 10 && k < 50);
        send_track(random_track());
      end
      calm = 1'b0;
    end

    trk_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (err_cnt == 0) begin
      $display("** helix_closest_approach_newton: PASSED **");
    end else begin
      $display("** helix_closest_approach_newton: FAILED **");
    end
    $finish;
  end

endmodule
